// File: rtl/sha384_hash_engine_macros.svh
// assertion macros for the sha384 hash engine
`ifndef SHA384_HASH_ENGINE_MACROS_SVH
`define SHA384_HASH_ENGINE_MACROS_SVH
// assert a property on the engine clock, disabled in reset
`define SHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// assert a property that also holds in reset
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// File: rtl/sha_pkg.sv
// constants, tables and functions for the sha384 hash engine
package sha_pkg;
    localparam int DIGEST_WORDS_DEF = 6;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS = 80;
    localparam logic [63:0] PAD_BYTE = 64'h80;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] h;
        case (i)
            3'd0: h = 64'hcbbb9d5dc1059ed8;
            3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17;
            3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31;
            3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7;
            default: h = 64'h47b5481dbefa4fa4;
        endcase
        return h;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // control flags from the sequencer to the round unit
    typedef struct packed {
        logic load;
        logic step;
        logic [6:0] round;
    } t_round_ctl;
endpackage

// File: rtl/sha_if.sv
// valid/ready channel interfaces for input and digest items
interface sha_in_if;
    logic valid;
    logic ready;
    logic [63:0] message_word;
    logic [3:0] valid_bytes;
    logic final_word;
    modport source (output valid, message_word, valid_bytes, final_word, input ready);
    modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha_out_if;
    logic valid;
    logic ready;
    logic [63:0] digest_word;
    logic [2:0] digest_index;
    logic last_digest;
    modport source (output valid, digest_word, digest_index, last_digest, input ready);
    modport sink (input valid, digest_word, digest_index, last_digest, output ready);
endinterface

// File: rtl/sha_ram.sv
// generic single port ram with registered read
module sha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/sha_round.sv
// working variables and one sha-512 round per cycle while step is set
module sha_round import sha_pkg::*; (
    input  logic        i_clk,
    input  t_round_ctl  i_ctl,
    input  logic [63:0] i_w,
    input  logic [63:0] i_init [8],
    output logic [63:0] o_vars [8]
);
    logic [63:0] r_v [8];
    logic [63:0] t1;
    logic [63:0] t2;

    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(i_ctl.round) + i_w;
        t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_init;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_vars = r_v;
endmodule

// File: rtl/sha384_hash_engine.sv
// top level of the sha384 hash engine
//  channel  dir  handshake        payload
//  s_in     in   valid/ready      message_word, valid_bytes, final_word
//  m_out    out  valid/ready      digest_word, digest_index, last_digest
// a data word passes S_IDLE and S_PUT; every 16th word adds a compression:
// load, 80 rounds and the chaining add; the schedule memory port is read four
// times per round and written in the last of its 5 phases from round 16 on
// a final word adds padding words, one per S_PUT pass, one or two compressions,
// then DIGEST_WORDS digest items at one per cycle when taken
// reset is synchronous active low and restores the initial chaining value at once
// output stalls hold the digest sequencer; input is not taken meanwhile
module sha384_hash_engine import sha_pkg::*; #(
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    s_in,
    sha_out_if.source m_out
);
    `include "sha384_hash_engine_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_PUT, S_LOAD, S_R0, S_R1, S_R2, S_R3, S_RS, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    logic [63:0] r_chain [8];
    logic [63:0] r_len;
    logic [3:0]  r_pos;
    logic [6:0]  r_round;
    logic [63:0] r_word;
    logic [1:0]  r_pad;     // 0 none, 1 pad word pending, 2 zero fill, 3 length
    logic        r_final;
    logic [2:0]  r_oidx;
    logic [63:0] r_acc;
    logic [63:0] r_w;

    logic        ram_we;
    logic [3:0]  ram_addr;
    logic [63:0] ram_wdata;
    logic [63:0] ram_rdata;
    t_round_ctl  ctl;
    logic [63:0] vars [8];
    logic [3:0]  cnt;
    logic [63:0] masked;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [3:0]  t4;
    logic [63:0] w_cur;

    sha_ram #(.WIDTH(64), .DEPTH(BLOCK_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    sha_round u_round (
        .i_clk(i_clk), .i_ctl(ctl), .i_w(w_cur), .i_init(r_chain), .o_vars(vars)
    );

    assign t4 = r_round[3:0];
    assign cnt = (!s_in.final_word || s_in.valid_bytes > 4'd8) ? 4'd8 : s_in.valid_bytes;
    assign masked = (cnt == 4'd0) ? 64'h0 : s_in.message_word & ~(64'hffffffffffffffff
                    >> ({3'd0, cnt} * 7'd8));
    assign s0 = rotr(r_acc, 1) ^ rotr(r_acc, 8) ^ (r_acc >> 7);
    assign s1 = rotr(ram_rdata, 19) ^ rotr(ram_rdata, 61) ^ (ram_rdata >> 6);
    // schedule word of the round, completed with the entry read for round t
    assign w_cur = (r_round >= 7'd16) ? r_w + ram_rdata : ram_rdata;

    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.digest_word = r_chain[r_oidx];
    assign m_out.digest_index = r_oidx;
    assign m_out.last_digest = (r_oidx == 3'(DIGEST_WORDS - 1));

    // schedule phases: R0 read t-2, R1 read t-15 (s1 held), R2 read t-7, R3 read t, RS write
    always_comb begin
        ram_we = 1'b0;
        ram_addr = t4;
        ram_wdata = r_word;
        ctl = '{load: 1'b0, step: 1'b0, round: r_round};
        unique case (r_state)
            S_PUT: begin
                ram_we = 1'b1;
                ram_addr = r_pos;
            end
            S_LOAD: ctl.load = 1'b1;
            S_R0: ram_addr = t4 - 4'd2;
            S_R1: ram_addr = t4 - 4'd15;
            S_R2: ram_addr = t4 - 4'd7;
            S_R3: ram_addr = t4;
            S_RS: begin
                ram_addr = t4;
                ram_we = (r_round >= 7'd16);
                ram_wdata = w_cur;
                ctl.step = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
            r_len <= '0;
            r_pos <= '0;
            r_round <= '0;
            r_pad <= '0;
            r_final <= 1'b0;
            r_oidx <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_in.valid) begin
                    r_len <= r_len + {57'd0, cnt, 3'd0};
                    r_final <= s_in.final_word;
                    if (!s_in.final_word) begin
                        r_word <= masked;
                        r_pad <= 2'd0;
                    end else if (cnt < 4'd8) begin
                        r_word <= masked | (PAD_BYTE << (7'd56 - {cnt, 3'd0}));
                        r_pad <= 2'd2;
                    end else begin
                        r_word <= masked;
                        r_pad <= 2'd1;
                    end
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    r_pos <= r_pos + 4'd1;
                    if (r_pos == 4'd15) begin
                        r_state <= S_LOAD;
                    end else if (!r_final) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PUT;
                    end
                    if (r_final) begin
                        if (r_pad == 2'd1) begin
                            r_word <= PAD_BYTE << 56;
                            r_pad <= 2'd2;
                        end else if (r_pos == 4'd14 && r_pad == 2'd2 && r_word == '0) begin
                            r_word <= r_len;
                            r_pad <= 2'd3;
                        end else if (r_pad == 2'd3) begin
                            r_word <= '0;
                            r_pad <= 2'd0;
                        end else begin
                            r_word <= '0;
                        end
                    end
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_R0;
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_w <= s1;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_acc <= ram_rdata;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_w <= (r_round >= 7'd16) ? r_w + s0 + ram_rdata : r_w;
                    r_acc <= ram_rdata;
                    r_state <= S_RS;
                end
                S_RS: begin
                    r_round <= r_round + 7'd1;
                    r_state <= (r_round == 7'(ROUNDS - 1)) ? S_ADD : S_R0;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + vars[i];
                    if (r_final && r_pad == 2'd0) begin
                        r_oidx <= '0;
                        r_state <= S_OUT;
                    end else if (r_final) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: if (m_out.ready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'(DIGEST_WORDS - 1)) begin
                        for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
                        r_len <= '0;
                        r_pos <= '0;
                        r_final <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SHA_ASSERT(a_no_accept_busy, s_in.valid && s_in.ready |=> !s_in.ready, "accept while busy")
    `SHA_ASSERT(a_out_idx, m_out.valid |-> {1'b0, m_out.digest_index} < 4'(DIGEST_WORDS), "bad index")
    `SHA_ASSERT(a_last_idle, m_out.valid && m_out.ready && m_out.last_digest |=> s_in.ready,
        "not idle after digest")
    `SHA_ASSERT(a_excl, !(s_in.ready && m_out.valid), "input and output together")
endmodule
